@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define AST_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/etok_pkg.sv @@
package etok_pkg;

  // Default width of the character position counter.
  localparam int POS_BITS_DEF = 16;

  // Result queue depth; a power of two, at least 2.
  localparam int OUTQ_DEPTH = 4;

  // Token kinds.
  localparam logic [2:0] KIND_OP   = 3'd0;
  localparam logic [2:0] KIND_NUM  = 3'd1;
  localparam logic [2:0] KIND_NAME = 3'd2;
  localparam logic [2:0] KIND_END  = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_NAME = 2'd2,
    MODE_DROP = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic [7:0]  symbol_char;
    logic        last_result;
  } tok_t;

  // Up to two results from one character beat, in order.
  typedef struct packed {
    logic v0;
    logic v1;
    tok_t r0;
    tok_t r1;
  } step_res_t;

endpackage

@@ rtl/etok_char_if.sv @@
interface etok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_mark;

  modport source(output valid, char_code, end_mark, input ready);
  modport sink(input valid, char_code, end_mark, output ready);
endinterface

@@ rtl/etok_tok_if.sv @@
interface etok_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] token_length;
  logic [7:0]  symbol_char;
  logic        last_result;

  modport source(output valid, token_kind, start_pos, token_length, symbol_char,
                 last_result, input ready);
  modport sink(input valid, token_kind, start_pos, token_length, symbol_char,
               last_result, output ready);
endinterface

@@ rtl/expression_tokenizer.sv @@
// Channel   Dir   Payload                                         Beat
// in_ch     in    char_code, end_mark                             one character or end mark
// out_ch    out   token_kind, start_pos, token_length,            one token result
//                 symbol_char, last_result
//
// One character beat per cycle while in_ch.ready is high; each gives zero, one or two result beats.
// Results go through a four-entry queue; in_ch.ready is high while it has at least two free slots.
// A stalled out_ch holds the queue; input keeps flowing until the queue is nearly full.
// Results are registered in the queue and appear on out_ch in order, behind any older results.
// Reset clears the scanner state and empties the queue.
module expression_tokenizer #(
  parameter int POS_BITS = etok_pkg::POS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  etok_char_if.sink         in_ch,
  etok_tok_if.source        out_ch
);

  logic                step, pop, nonempty, room2;
  etok_pkg::step_res_t res;
  etok_pkg::tok_t      head;

  assign step = in_ch.valid && in_ch.ready;
  assign pop  = out_ch.valid && out_ch.ready;

  etok_core #(.POS_BITS(POS_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (in_ch.char_code),
    .end_mark  (in_ch.end_mark),
    .res       (res)
  );

  etok_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (step),
    .res      (res),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .room2    (room2)
  );

  // Drive the channels.
  assign in_ch.ready         = room2;
  assign out_ch.valid        = nonempty;
  assign out_ch.token_kind   = head.token_kind;
  assign out_ch.start_pos    = head.start_pos;
  assign out_ch.token_length = head.token_length;
  assign out_ch.symbol_char  = head.symbol_char;
  assign out_ch.last_result  = head.last_result;

endmodule

@@ rtl/etok_core.sv @@
module etok_core #(
  parameter int POS_BITS = etok_pkg::POS_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          char_code,
  input  logic                end_mark,
  output etok_pkg::step_res_t res
);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [15:0] LEN_MAX  = 16'hFFFF;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  etok_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic                 seen_dot, seen_dot_next;
  logic [POS_BITS-1:0]  char_position, char_position_next;
  logic [POS_BITS-1:0]  token_start, token_start_next;
  logic [15:0]          token_count_len, token_count_len_next;

  logic        is_dig, is_alp, is_spc, is_op, is_dot;
  logic [47:0] pos_wide, start_wide;
  logic [15:0] pos_sat, start_sat, len_ext;
  logic        close_v, sec_v, do_start;
  etok_pkg::tok_t close_r, sec_r;

  // Classify the incoming byte.
  assign is_dig = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_alp = ((char_code >= 8'h41) && (char_code <= 8'h5A)) ||
                  ((char_code >= 8'h61) && (char_code <= 8'h7A));
  assign is_spc = (char_code == 8'h20) || ((char_code >= 8'h09) && (char_code <= 8'h0D));
  assign is_op  = (char_code == CH_LPAREN) || (char_code == CH_RPAREN) ||
                  (char_code == CH_PLUS) || (char_code == CH_MINUS) ||
                  (char_code == CH_STAR) || (char_code == CH_SLASH) ||
                  (char_code == CH_CARET);
  assign is_dot = (char_code == CH_DOT);

  // Clamp positions to the 16-bit field.
  assign pos_wide  = 48'(char_position);
  assign start_wide = 48'(token_start);
  assign pos_sat   = (pos_wide > 48'hFFFF) ? 16'hFFFF : pos_wide[15:0];
  assign start_sat = (start_wide > 48'hFFFF) ? 16'hFFFF : start_wide[15:0];
  assign len_ext   = (token_count_len != LEN_MAX) ? token_count_len + 16'd1
                                                  : token_count_len;

  // Next state and the results of this beat.
  always_comb begin
    scan_mode_next       = scan_mode;
    seen_dot_next        = seen_dot;
    char_position_next   = char_position;
    token_start_next     = token_start;
    token_count_len_next = token_count_len;
    close_v  = 1'b0;
    sec_v    = 1'b0;
    do_start = 1'b0;

    close_r.token_kind   = (scan_mode == etok_pkg::MODE_NAME) ? etok_pkg::KIND_NAME
                                                              : etok_pkg::KIND_NUM;
    close_r.start_pos    = start_sat;
    close_r.token_length = token_count_len;
    close_r.symbol_char  = 8'd0;
    close_r.last_result  = 1'b0;

    sec_r.token_kind   = etok_pkg::KIND_END;
    sec_r.start_pos    = pos_sat;
    sec_r.token_length = 16'd0;
    sec_r.symbol_char  = 8'd0;
    sec_r.last_result  = 1'b1;

    if (end_mark) begin
      close_v = (scan_mode == etok_pkg::MODE_NUM) || (scan_mode == etok_pkg::MODE_NAME);
      sec_v   = 1'b1;
      scan_mode_next       = etok_pkg::MODE_IDLE;
      seen_dot_next        = 1'b0;
      char_position_next   = '0;
      token_start_next     = '0;
      token_count_len_next = 16'd0;
    end else begin
      case (scan_mode)
        etok_pkg::MODE_NUM: begin
          if (is_dig) begin
            token_count_len_next = len_ext;
          end else if (is_dot) begin
            if (seen_dot) begin
              sec_v = 1'b1;
              sec_r.token_kind   = etok_pkg::KIND_ERR;
              sec_r.token_length = 16'd1;
              sec_r.symbol_char  = char_code;
              scan_mode_next     = etok_pkg::MODE_DROP;
            end else begin
              seen_dot_next        = 1'b1;
              token_count_len_next = len_ext;
            end
          end else begin
            close_v  = 1'b1;
            do_start = 1'b1;
          end
        end
        etok_pkg::MODE_NAME: begin
          if (is_alp) begin
            token_count_len_next = len_ext;
          end else begin
            close_v  = 1'b1;
            do_start = 1'b1;
          end
        end
        etok_pkg::MODE_IDLE: begin
          do_start = 1'b1;
        end
        default: begin
        end
      endcase

      // Handle the byte as the start of a new token.
      if (do_start) begin
        scan_mode_next = etok_pkg::MODE_IDLE;
        if (is_spc) begin
        end else if (is_op) begin
          sec_v = 1'b1;
          sec_r.token_kind   = etok_pkg::KIND_OP;
          sec_r.token_length = 16'd1;
          sec_r.symbol_char  = char_code;
        end else if (is_dig || is_alp) begin
          token_start_next     = char_position;
          token_count_len_next = 16'd1;
          seen_dot_next        = 1'b0;
          scan_mode_next       = is_dig ? etok_pkg::MODE_NUM : etok_pkg::MODE_NAME;
        end else begin
          sec_v = 1'b1;
          sec_r.token_kind   = etok_pkg::KIND_ERR;
          sec_r.token_length = 16'd1;
          sec_r.symbol_char  = char_code;
          scan_mode_next     = etok_pkg::MODE_DROP;
        end
      end

      // Advance the position, saturating.
      if (char_position != POS_MAX) begin
        char_position_next = char_position + 1'b1;
      end
    end
  end

  // Pack results in order and mark the final one.
  always_comb begin
    res.v0 = close_v || sec_v;
    res.v1 = close_v && sec_v;
    res.r0 = close_v ? close_r : sec_r;
    res.r0.last_result = !(close_v && sec_v);
    res.r1 = sec_r;
    res.r1.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= etok_pkg::MODE_IDLE;
      seen_dot        <= 1'b0;
      char_position   <= '0;
      token_start     <= '0;
      token_count_len <= 16'd0;
    end else if (step) begin
      scan_mode       <= scan_mode_next;
      seen_dot        <= seen_dot_next;
      char_position   <= char_position_next;
      token_start     <= token_start_next;
      token_count_len <= token_count_len_next;
    end
  end

endmodule

@@ rtl/etok_outq.sv @@
module etok_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  etok_pkg::step_res_t res,
  input  logic                pop,
  output etok_pkg::tok_t      head,
  output logic                nonempty,
  output logic                room2
);

  localparam int DEPTH    = etok_pkg::OUTQ_DEPTH;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  etok_pkg::tok_t      q [DEPTH];
  logic [PTR_BITS-1:0] wptr, rptr, wptr_next, rptr_next, wptr_p1;
  logic [CNT_BITS-1:0] count, count_next;
  logic [1:0]          n_in;

  assign wptr_p1 = wptr + 1'b1;
  assign n_in    = push ? (2'(res.v0) + 2'(res.v1)) : 2'd0;

  // Track fill level and pointers.
  always_comb begin
    wptr_next  = wptr + PTR_BITS'(n_in);
    rptr_next  = pop ? rptr + 1'b1 : rptr;
    count_next = count + CNT_BITS'(n_in) - CNT_BITS'(pop);
  end

  assign head     = q[rptr];
  assign nonempty = (count != '0);
  assign room2    = (count <= CNT_BITS'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr_next;
      rptr  <= rptr_next;
      count <= count_next;
    end
  end

  // Write up to two results per beat.
  always_ff @(posedge clk) begin
    if (push && res.v0) begin
      q[wptr] <= res.r0;
    end
    if (push && res.v1) begin
      q[wptr_p1] <= res.r1;
    end
  end

endmodule

@@ rtl/etok_checker.sv @@
`include "assert_macros.svh"

module etok_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  token_kind,
  input logic [15:0] token_length,
  input logic [7:0]  symbol_char,
  input logic        last_result
);

  logic was_rst;

  always_ff @(posedge clk) begin
    was_rst <= rst;
  end

  // Hold a stalled result beat.
  `AST_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // End token is empty and closes its item.
  `AST_IMPLY(a_end_shape, clk, rst, out_valid && (token_kind == etok_pkg::KIND_END),
             (token_length == 16'd0) && (symbol_char == 8'd0) && last_result)

  // Operator and error tokens cover one character.
  `AST_IMPLY(a_single_len, clk, rst,
             out_valid && ((token_kind == etok_pkg::KIND_OP) ||
                           (token_kind == etok_pkg::KIND_ERR)),
             token_length == 16'd1)

  // Number and name tokens are never empty and carry no symbol.
  `AST_IMPLY(a_run_shape, clk, rst,
             out_valid && ((token_kind == etok_pkg::KIND_NUM) ||
                           (token_kind == etok_pkg::KIND_NAME)),
             (token_length != 16'd0) && (symbol_char == 8'd0))

  // Come out of reset with no result pending.
  `AST_IMPLY(a_reset_empty, clk, rst, was_rst, !out_valid)

endmodule

bind expression_tokenizer etok_checker u_etok_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_kind   (out_ch.token_kind),
  .token_length (out_ch.token_length),
  .symbol_char  (out_ch.symbol_char),
  .last_result  (out_ch.last_result)
);
